### rtl/core/cpsn_pkg.sv
// Package for the cross-power spectrum normaliser.
// Holds default widths and the fixed normalisation constants; no dependencies.
package cpsn_pkg;

   // default input sample width and output fraction bits
   localparam int DEF_IN_WIDTH      = 24;
   localparam int DEF_OUT_FRAC_BITS = 15;

   // product magnitudes are normalised to this bit length before the root
   localparam int NORM_BITS = 31;
   // root result bits, one per pipeline step
   localparam int SQRT_STEPS = 32;
   // width of the radicand and the root accumulator
   localparam int SQ_WIDTH = 64;
   // partial remainder width in the divider
   localparam int REM_WIDTH = 34;

endpackage

### rtl/core/cpsn_req_if.sv
// Stream interfaces for the cross-power spectrum normaliser.
// Depends on cpsn_pkg for the default widths.
interface cpsn_req_if
   import cpsn_pkg::*;
#(
   parameter int IN_WIDTH = DEF_IN_WIDTH
);
   logic                       valid;
   logic                       ready;
   logic signed [IN_WIDTH-1:0] ref_re;
   logic signed [IN_WIDTH-1:0] ref_im;
   logic signed [IN_WIDTH-1:0] shift_re;
   logic signed [IN_WIDTH-1:0] shift_im;

   modport source (output valid, ref_re, ref_im, shift_re, shift_im, input ready);
   modport sink   (input valid, ref_re, ref_im, shift_re, shift_im, output ready);
endinterface

interface cpsn_rsp_if
   import cpsn_pkg::*;
#(
   parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [OUT_FRAC_BITS:0] norm_re;
   logic signed [OUT_FRAC_BITS:0] norm_im;
   logic                          zero_magnitude;

   modport source (output valid, norm_re, norm_im, zero_magnitude, input ready);
   modport sink   (input valid, norm_re, norm_im, zero_magnitude, output ready);
endinterface

### rtl/core/cross_power_spectrum_normalizer_top.sv
// Cross-power spectrum normaliser: phase-correlation term per spectrum pair.
// Depends on cpsn_pkg and the stream interfaces in cpsn_req_if.sv.
//
// Usage
//   req_bus carries one beat per pair of complex spectrum elements
//   (reference a+bi, shifted c+di). rsp_bus returns one beat per request:
//   (a+bi)(c-di) / |(a+bi)(c-di)| as signed fractions with OUT_FRAC_BITS
//   fraction bits, saturated. A zero product gives zeros and zero_magnitude.
// Timing
//   Fully pipelined, one beat per cycle sustained while rsp_bus takes beats.
//   Stages from request accept to response valid, in order: products, sums,
//   magnitudes, leading-one search (two stages), normalising shift, squares,
//   32 root steps, then one restoring-divide step per quotient bit and the
//   saturation stage.
// Reset
//   Synchronous reset clears all stage valid bits; data registers are
//   left as they are. The block is ready in the cycle after reset.
// Stalls
//   When rsp_bus is stalled with a beat waiting, the whole pipeline holds
//   and req_bus.ready drops; nothing is lost or repeated.
module cross_power_spectrum_normalizer_top
   import cpsn_pkg::*;
#(
   parameter int IN_WIDTH      = DEF_IN_WIDTH,
   parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
   input  logic       clock,
   input  logic       reset,
   cpsn_req_if.sink   req_bus,
   cpsn_rsp_if.source rsp_bus
);

   localparam int PW   = 2 * IN_WIDTH;          // product width
   localparam int SW   = PW + 1;                // sum width
   localparam int MW   = PW;                    // magnitude width
   localparam int NCH  = (MW + 7) / 8;          // byte chunks in a magnitude
   localparam int LW   = $clog2(MW + 1);        // bit-length width
   localparam int SHW  = MW + NORM_BITS;        // shifter width
   localparam int OW   = OUT_FRAC_BITS + 1;     // output width
   localparam int QW   = OUT_FRAC_BITS + 2;     // quotient width
   localparam int NW   = NORM_BITS + OUT_FRAC_BITS + 1; // dividend width
   localparam int NSTG = 7 + (SQRT_STEPS + 1) + (QW + 1) + 1;

   // pipeline advance: last stage empty or being taken
   logic en;
   logic [NSTG-1:0] vld_ff, vld_in;

   assign en            = !vld_ff[NSTG-1] || rsp_bus.ready;
   assign req_bus.ready = en;
   assign vld_in        = {vld_ff[NSTG-2:0], req_bus.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: four partial products
   logic signed [PW-1:0] s1_ac_ff, s1_bd_ff, s1_bc_ff, s1_ad_ff;
   logic signed [PW-1:0] s1_ac_in, s1_bd_in, s1_bc_in, s1_ad_in;

   always_comb begin
      s1_ac_in = PW'(req_bus.ref_re) * PW'(req_bus.shift_re);
      s1_bd_in = PW'(req_bus.ref_im) * PW'(req_bus.shift_im);
      s1_bc_in = PW'(req_bus.ref_im) * PW'(req_bus.shift_re);
      s1_ad_in = PW'(req_bus.ref_re) * PW'(req_bus.shift_im);
   end

   // stage 2: real and imaginary parts of a * conj(c)
   logic signed [SW-1:0] s2_p_ff, s2_q_ff, s2_p_in, s2_q_in;

   always_comb begin
      s2_p_in = SW'(s1_ac_ff) + SW'(s1_bd_ff);
      s2_q_in = SW'(s1_bc_ff) - SW'(s1_ad_ff);
   end

   // stage 3: sign and magnitude, larger magnitude
   logic [MW-1:0] s3_pm_ff, s3_qm_ff, s3_m_ff, s3_pm_in, s3_qm_in, s3_m_in;
   logic          s3_np_ff, s3_nq_ff, s3_np_in, s3_nq_in;

   always_comb begin
      s3_np_in = s2_p_ff[SW-1];
      s3_nq_in = s2_q_ff[SW-1];
      s3_pm_in = s3_np_in ? MW'(-s2_p_ff) : MW'(s2_p_ff);
      s3_qm_in = s3_nq_in ? MW'(-s2_q_ff) : MW'(s2_q_ff);
      s3_m_in  = (s3_pm_in > s3_qm_in) ? s3_pm_in : s3_qm_in;
   end

   // stage 4: leading one within each byte chunk
   logic [MW-1:0]    s4_pm_ff, s4_qm_ff;
   logic             s4_np_ff, s4_nq_ff;
   logic [NCH-1:0]   s4_nz_ff, s4_nz_in;
   logic [2:0]       s4_pos_ff [NCH];
   logic [2:0]       s4_pos_in [NCH];
   logic [NCH*8-1:0] s4_mpad;

   always_comb begin
      s4_mpad = (NCH * 8)'(s3_m_ff);
      for (int c = 0; c < NCH; c++) begin
         s4_nz_in[c]  = |s4_mpad[c*8 +: 8];
         s4_pos_in[c] = '0;
         for (int b = 0; b < 8; b++) begin
            if (s4_mpad[c*8 + b]) begin
               s4_pos_in[c] = 3'(b);
            end
         end
      end
   end

   // stage 5: bit length of the larger magnitude
   logic [MW-1:0] s5_pm_ff, s5_qm_ff;
   logic          s5_np_ff, s5_nq_ff;
   logic [LW-1:0] s5_len_ff, s5_len_in;

   always_comb begin
      s5_len_in = '0;
      for (int c = 0; c < NCH; c++) begin
         if (s4_nz_ff[c]) begin
            s5_len_in = LW'(c * 8) + LW'(s4_pos_ff[c]) + LW'(1);
         end
      end
   end

   // stage 6: normalise both magnitudes to NORM_BITS (truncating right shift)
   logic [NORM_BITS-1:0] s6_p_ff, s6_q_ff, s6_p_in, s6_q_in;
   logic                 s6_np_ff, s6_nq_ff, s6_zero_ff;
   logic [SHW-1:0]       s6_psh, s6_qsh;

   always_comb begin
      s6_psh  = {s5_pm_ff, NORM_BITS'(0)} >> s5_len_ff;
      s6_qsh  = {s5_qm_ff, NORM_BITS'(0)} >> s5_len_ff;
      s6_p_in = s6_psh[NORM_BITS-1:0];
      s6_q_in = s6_qsh[NORM_BITS-1:0];
   end

   // stage 7: squares
   logic [2*NORM_BITS-1:0] s7_p2_ff, s7_q2_ff;
   logic [NORM_BITS-1:0]   s7_p_ff, s7_q_ff;
   logic                   s7_np_ff, s7_nq_ff, s7_zero_ff;

   // root pipeline: entry 0 holds the radicand, one result bit per step
   logic [SQ_WIDTH-1:0]  sq_s_ff   [SQRT_STEPS+1];
   logic [SQ_WIDTH-1:0]  sq_res_ff [SQRT_STEPS+1];
   logic [SQ_WIDTH-1:0]  sq_s_in   [SQRT_STEPS];
   logic [SQ_WIDTH-1:0]  sq_res_in [SQRT_STEPS];
   logic [NORM_BITS-1:0] sq_p_ff   [SQRT_STEPS+1];
   logic [NORM_BITS-1:0] sq_q_ff   [SQRT_STEPS+1];
   logic                 sq_np_ff  [SQRT_STEPS+1];
   logic                 sq_nq_ff  [SQRT_STEPS+1];
   logic                 sq_zero_ff[SQRT_STEPS+1];
   logic [SQ_WIDTH-1:0]  sq_bit    [SQRT_STEPS];
   logic [SQ_WIDTH-1:0]  sq_try    [SQRT_STEPS];

   always_comb begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
         sq_bit[k] = SQ_WIDTH'(1) << (SQ_WIDTH - 2 - 2 * k);
         sq_try[k] = sq_res_ff[k] + sq_bit[k];
         if (sq_s_ff[k] >= sq_try[k]) begin
            sq_s_in[k]   = sq_s_ff[k] - sq_try[k];
            sq_res_in[k] = (sq_res_ff[k] >> 1) + sq_bit[k];
         end else begin
            sq_s_in[k]   = sq_s_ff[k];
            sq_res_in[k] = sq_res_ff[k] >> 1;
         end
      end
   end

   // divider: entry 0 set up from the root, one quotient bit per step
   logic [REM_WIDTH-1:0] dv_re_rem_ff [QW+1];
   logic [REM_WIDTH-1:0] dv_im_rem_ff [QW+1];
   logic [QW-1:0]        dv_re_quo_ff [QW+1];
   logic [QW-1:0]        dv_im_quo_ff [QW+1];
   logic [NW-1:0]        dv_re_num_ff [QW+1];
   logic [NW-1:0]        dv_im_num_ff [QW+1];
   logic [NORM_BITS:0]   dv_r_ff      [QW+1];
   logic                 dv_np_ff     [QW+1];
   logic                 dv_nq_ff     [QW+1];
   logic                 dv_zero_ff   [QW+1];
   logic [NORM_BITS:0]   dv_r_in;
   logic [NW-1:0]        dv_re_num_in, dv_im_num_in;
   logic [REM_WIDTH-1:0] dv_re_t [QW];
   logic [REM_WIDTH-1:0] dv_im_t [QW];
   logic [REM_WIDTH-1:0] dv_re_rem_in [QW];
   logic [REM_WIDTH-1:0] dv_im_rem_in [QW];
   logic                 dv_re_bit [QW];
   logic                 dv_im_bit [QW];

   // dividend with half the divisor added for round-half-up
   always_comb begin
      dv_r_in      = sq_res_ff[SQRT_STEPS][NORM_BITS:0];
      dv_re_num_in = {1'b0, sq_p_ff[SQRT_STEPS], OUT_FRAC_BITS'(0)} + NW'(dv_r_in >> 1);
      dv_im_num_in = {1'b0, sq_q_ff[SQRT_STEPS], OUT_FRAC_BITS'(0)} + NW'(dv_r_in >> 1);
   end

   always_comb begin
      for (int j = 0; j < QW; j++) begin
         dv_re_t[j]   = {dv_re_rem_ff[j][REM_WIDTH-2:0], dv_re_num_ff[j][QW-1-j]};
         dv_im_t[j]   = {dv_im_rem_ff[j][REM_WIDTH-2:0], dv_im_num_ff[j][QW-1-j]};
         dv_re_bit[j] = dv_re_t[j] >= REM_WIDTH'(dv_r_ff[j]);
         dv_im_bit[j] = dv_im_t[j] >= REM_WIDTH'(dv_r_ff[j]);
         dv_re_rem_in[j] = dv_re_bit[j] ? dv_re_t[j] - REM_WIDTH'(dv_r_ff[j]) : dv_re_t[j];
         dv_im_rem_in[j] = dv_im_bit[j] ? dv_im_t[j] - REM_WIDTH'(dv_r_ff[j]) : dv_im_t[j];
      end
   end

   // output stage: sign, saturation, zero forcing
   localparam logic [QW-1:0] FULL = QW'(1) << OUT_FRAC_BITS;
   logic [QW-1:0]        out_re_mag, out_im_mag;
   logic signed [OW-1:0] out_re_ff, out_im_ff, out_re_in, out_im_in;
   logic                 out_zero_ff;

   always_comb begin
      out_re_mag = dv_re_quo_ff[QW];
      out_im_mag = dv_im_quo_ff[QW];
      if (dv_np_ff[QW]) begin
         if (out_re_mag > FULL) out_re_mag = FULL;
         out_re_in = OW'(-out_re_mag);
      end else begin
         if (out_re_mag > FULL - 1'b1) out_re_mag = FULL - 1'b1;
         out_re_in = OW'(out_re_mag);
      end
      if (dv_nq_ff[QW]) begin
         if (out_im_mag > FULL) out_im_mag = FULL;
         out_im_in = OW'(-out_im_mag);
      end else begin
         if (out_im_mag > FULL - 1'b1) out_im_mag = FULL - 1'b1;
         out_im_in = OW'(out_im_mag);
      end
      if (dv_zero_ff[QW]) begin
         out_re_in = '0;
         out_im_in = '0;
      end
   end

   // data registers, all advancing together
   always_ff @(posedge clock) begin
      if (en) begin
         s1_ac_ff <= s1_ac_in;
         s1_bd_ff <= s1_bd_in;
         s1_bc_ff <= s1_bc_in;
         s1_ad_ff <= s1_ad_in;

         s2_p_ff <= s2_p_in;
         s2_q_ff <= s2_q_in;

         s3_pm_ff <= s3_pm_in;
         s3_qm_ff <= s3_qm_in;
         s3_m_ff  <= s3_m_in;
         s3_np_ff <= s3_np_in;
         s3_nq_ff <= s3_nq_in;

         s4_pm_ff  <= s3_pm_ff;
         s4_qm_ff  <= s3_qm_ff;
         s4_np_ff  <= s3_np_ff;
         s4_nq_ff  <= s3_nq_ff;
         s4_nz_ff  <= s4_nz_in;
         s4_pos_ff <= s4_pos_in;

         s5_pm_ff  <= s4_pm_ff;
         s5_qm_ff  <= s4_qm_ff;
         s5_np_ff  <= s4_np_ff;
         s5_nq_ff  <= s4_nq_ff;
         s5_len_ff <= s5_len_in;

         s6_p_ff    <= s6_p_in;
         s6_q_ff    <= s6_q_in;
         s6_np_ff   <= s5_np_ff;
         s6_nq_ff   <= s5_nq_ff;
         s6_zero_ff <= (s5_len_ff == '0);

         s7_p2_ff   <= (2*NORM_BITS)'(s6_p_ff) * (2*NORM_BITS)'(s6_p_ff);
         s7_q2_ff   <= (2*NORM_BITS)'(s6_q_ff) * (2*NORM_BITS)'(s6_q_ff);
         s7_p_ff    <= s6_p_ff;
         s7_q_ff    <= s6_q_ff;
         s7_np_ff   <= s6_np_ff;
         s7_nq_ff   <= s6_nq_ff;
         s7_zero_ff <= s6_zero_ff;

         sq_s_ff[0]    <= SQ_WIDTH'(s7_p2_ff) + SQ_WIDTH'(s7_q2_ff);
         sq_res_ff[0]  <= '0;
         sq_p_ff[0]    <= s7_p_ff;
         sq_q_ff[0]    <= s7_q_ff;
         sq_np_ff[0]   <= s7_np_ff;
         sq_nq_ff[0]   <= s7_nq_ff;
         sq_zero_ff[0] <= s7_zero_ff;
         for (int k = 0; k < SQRT_STEPS; k++) begin
            sq_s_ff[k+1]    <= sq_s_in[k];
            sq_res_ff[k+1]  <= sq_res_in[k];
            sq_p_ff[k+1]    <= sq_p_ff[k];
            sq_q_ff[k+1]    <= sq_q_ff[k];
            sq_np_ff[k+1]   <= sq_np_ff[k];
            sq_nq_ff[k+1]   <= sq_nq_ff[k];
            sq_zero_ff[k+1] <= sq_zero_ff[k];
         end

         dv_re_num_ff[0] <= dv_re_num_in;
         dv_im_num_ff[0] <= dv_im_num_in;
         dv_re_rem_ff[0] <= REM_WIDTH'(dv_re_num_in >> QW);
         dv_im_rem_ff[0] <= REM_WIDTH'(dv_im_num_in >> QW);
         dv_re_quo_ff[0] <= '0;
         dv_im_quo_ff[0] <= '0;
         dv_r_ff[0]      <= dv_r_in;
         dv_np_ff[0]     <= sq_np_ff[SQRT_STEPS];
         dv_nq_ff[0]     <= sq_nq_ff[SQRT_STEPS];
         dv_zero_ff[0]   <= sq_zero_ff[SQRT_STEPS];
         for (int j = 0; j < QW; j++) begin
            dv_re_num_ff[j+1] <= dv_re_num_ff[j];
            dv_im_num_ff[j+1] <= dv_im_num_ff[j];
            dv_re_rem_ff[j+1] <= dv_re_rem_in[j];
            dv_im_rem_ff[j+1] <= dv_im_rem_in[j];
            dv_re_quo_ff[j+1] <= {dv_re_quo_ff[j][QW-2:0], dv_re_bit[j]};
            dv_im_quo_ff[j+1] <= {dv_im_quo_ff[j][QW-2:0], dv_im_bit[j]};
            dv_r_ff[j+1]      <= dv_r_ff[j];
            dv_np_ff[j+1]     <= dv_np_ff[j];
            dv_nq_ff[j+1]     <= dv_nq_ff[j];
            dv_zero_ff[j+1]   <= dv_zero_ff[j];
         end

         out_re_ff   <= out_re_in;
         out_im_ff   <= out_im_in;
         out_zero_ff <= dv_zero_ff[QW];
      end
   end

   assign rsp_bus.valid          = vld_ff[NSTG-1];
   assign rsp_bus.norm_re        = out_re_ff;
   assign rsp_bus.norm_im        = out_im_ff;
   assign rsp_bus.zero_magnitude = out_zero_ff;

endmodule

### rtl/core/cpsn_checker.sv
// Port-level checks for the cross-power spectrum normaliser.
// Depends on cpsn_pkg; bound to cross_power_spectrum_normalizer_top.
module cpsn_checker
   import cpsn_pkg::*;
#(
   parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [OUT_FRAC_BITS:0] norm_re,
   input logic [OUT_FRAC_BITS:0] norm_im,
   input logic                   zero_magnitude
);

   // a stalled response beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // pipeline never pushes back while the receiver takes beats
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled with receiver ready");

   // zero magnitude forces zero outputs
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && zero_magnitude |-> norm_re == '0 && norm_im == '0)
      else $error("zero magnitude with non-zero output");

   // pipeline is empty straight after a reset cycle
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind cross_power_spectrum_normalizer_top cpsn_checker #(
   .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_cpsn_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .norm_re        (rsp_bus.norm_re),
   .norm_im        (rsp_bus.norm_im),
   .zero_magnitude (rsp_bus.zero_magnitude)
);

### tb/sv/tb_cross_power_spectrum_normalizer_top.sv
// Testbench for the cross-power spectrum normaliser: directed table, then random beats.
// Depends on cpsn_pkg, the stream interfaces in cpsn_req_if.sv and the top level RTL.
module tb_cross_power_spectrum_normalizer_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cpsn_pkg::*;

   localparam int IW = DEF_IN_WIDTH;
   localparam int FB = DEF_OUT_FRAC_BITS;
   localparam int LATENCY = 7 + 33 + FB + 3;
   localparam int N_RANDOM = 1080;
   localparam logic signed [IW-1:0] IN_MAX = {1'b0, {(IW-1){1'b1}}};
   localparam logic signed [IW-1:0] IN_MIN = {1'b1, {(IW-1){1'b0}}};
   localparam logic signed [FB:0] OUT_MAX = {1'b0, {FB{1'b1}}};
   localparam logic signed [FB:0] OUT_MIN = {1'b1, {FB{1'b0}}};

   typedef struct packed {
      logic signed [IW-1:0] a;
      logic signed [IW-1:0] b;
      logic signed [IW-1:0] c;
      logic signed [IW-1:0] d;
   } pair_type;

   typedef struct packed {
      logic signed [FB:0] re;
      logic signed [FB:0] im;
      logic               zero;
   } norm_type;

   typedef struct packed {
      pair_type pair;
      logic     typed;   // expected value typed in the table
      norm_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cpsn_req_if #(.IN_WIDTH(IW)) req_bus ();
   cpsn_rsp_if #(.OUT_FRAC_BITS(FB)) rsp_bus ();

   cross_power_spectrum_normalizer_top #(.IN_WIDTH(IW), .OUT_FRAC_BITS(FB)) dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   norm_type expected_norms[$];
   int       mismatches = 0;
   bit       stim_done = 1'b0;
   bit       hold_rsp = 1'b0;
   bit       calm = 1'b0;     // stretch with no idling on either side

   // rounded quotient, saturated to the output range
   function automatic logic signed [FB:0] scale_part(bit neg, longint unsigned p,
                                                     longint unsigned r);
      longint unsigned q;
      q = ((p << FB) + (r >> 1)) / r;
      if (neg) begin
         if (q > (64'd1 << FB)) q = 64'd1 << FB;
         return (FB+1)'(-$signed({1'b0, q[FB:0]}));
      end
      if (q > (64'd1 << FB) - 1) q = (64'd1 << FB) - 1;
      return q[FB:0];
   endfunction

   // exact P+Qi = (a+bi)(c-di), normalised to 31 bits, then divided by the root
   function automatic norm_type cross_power_norm(pair_type x);
      norm_type        res;
      logic signed [63:0] pp, qq;
      longint unsigned pm, qm, m, s, root, bitv;
      int              len;
      pp = 64'(x.a) * 64'(x.c) + 64'(x.b) * 64'(x.d);
      qq = 64'(x.b) * 64'(x.c) - 64'(x.a) * 64'(x.d);
      pm = pp < 0 ? -pp : pp;
      qm = qq < 0 ? -qq : qq;
      m = pm > qm ? pm : qm;
      if (m == 0) return '{re: '0, im: '0, zero: 1'b1};
      len = 0;
      while ((m >> len) != 0) len++;
      if (len > NORM_BITS) begin
         pm = pm >> (len - NORM_BITS);
         qm = qm >> (len - NORM_BITS);
      end else begin
         pm = pm << (NORM_BITS - len);
         qm = qm << (NORM_BITS - len);
      end
      s = pm * pm + qm * qm;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (s >= root + bitv) begin
            s = s - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      res.re = scale_part(pp < 0, pm, root);
      res.im = scale_part(qq < 0, qm, root);
      res.zero = 1'b0;
      return res;
   endfunction

   // offer one beat, holding it until accepted
   task automatic send_pair(pair_type x);
      while (!calm && $urandom_range(99) < 35) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.ref_re   <= x.a;
      req_bus.ref_im   <= x.b;
      req_bus.shift_re <= x.c;
      req_bus.shift_im <= x.d;
      do @(posedge clock); while (!req_bus.ready);
      expected_norms.push_back(cross_power_norm(x));
   endtask

   function automatic logic signed [IW-1:0] rand_field();
      case ($urandom_range(5))
         0: return IN_MAX;
         1: return IN_MIN;
         2: return IW'($signed($urandom_range(16)) - 8);
         default: return IW'($urandom);
      endcase
   endfunction

   row_type rows[$];

   // stimulus: directed table, then random beats
   initial begin
      pair_type x;
      norm_type got;
      req_bus.valid <= 1'b0;
      req_bus.ref_re <= '0;
      req_bus.ref_im <= '0;
      req_bus.shift_re <= '0;
      req_bus.shift_im <= '0;
      rows = '{
         '{'{'0, '0, '0, '0}, 1'b1, '{'0, '0, 1'b1}},                // all zero
         '{'{IW'(5), IW'(-3), '0, '0}, 1'b1, '{'0, '0, 1'b1}},       // shifted zero
         '{'{'0, '0, IN_MIN, IN_MAX}, 1'b1, '{'0, '0, 1'b1}},        // reference zero
         '{'{IW'(1), '0, IW'(1), '0}, 1'b1, '{OUT_MAX, '0, 1'b0}},   // +1 saturates
         '{'{IW'(-1), '0, IW'(1), '0}, 1'b1, '{OUT_MIN, '0, 1'b0}},  // -1 exact
         '{'{'0, IW'(1), IW'(1), '0}, 1'b1, '{'0, OUT_MAX, 1'b0}},
         '{'{'0, IW'(1), IW'(-1), '0}, 1'b1, '{'0, OUT_MIN, 1'b0}},
         '{'{IN_MAX, IN_MAX, IN_MAX, IN_MAX}, 1'b0, '0},
         '{'{IN_MIN, IN_MIN, IN_MIN, IN_MIN}, 1'b0, '0},
         '{'{IN_MIN, IN_MAX, IN_MAX, IN_MIN}, 1'b0, '0},
         '{'{IN_MIN, IN_MIN, IN_MAX, IN_MIN}, 1'b0, '0},
         '{'{IN_MAX, '0, '0, IN_MIN}, 1'b0, '0},
         '{'{IW'(3), IW'(4), IW'(1), '0}, 1'b0, '0},
         '{'{IW'(1), IW'(1), IW'(1), IW'(-1)}, 1'b0, '0},
         '{'{IW'(-1), IW'(-1), IW'(-1), IW'(-1)}, 1'b0, '0},
         '{'{IW'(7), IW'(-2), IW'(-5), IW'(9)}, 1'b0, '0},
         '{'{IW'(1), IW'(2), IW'(3), IW'(4)}, 1'b0, '0},
         '{'{IW'(123456), IW'(-654321), IW'(-1), IW'(2)}, 1'b0, '0},
         '{'{IW'(24'h555555), IW'(24'hAAAAAA), IW'(24'h0F0F0F), IW'(24'hF0F0F0)}, 1'b0, '0}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) begin
         send_pair(rows[i].pair);
         if (rows[i].typed) begin
            got = expected_norms[$];
            if (got !== rows[i].want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("table row %0d: predictor gives %p, table %p",
                           i, got, rows[i].want);
            end
         end
      end
      for (int n = 0; n < N_RANDOM; n++) begin
         calm = (n >= 300 && n < 450);
         x.a = rand_field();
         x.b = rand_field();
         x.c = rand_field();
         x.d = rand_field();
         // occasional zero-product beats
         if ($urandom_range(19) == 0) begin
            x.c = '0;
            x.d = '0;
         end
         send_pair(x);
      end
      req_bus.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // long receiver hold-off so the pipeline fills and stalls the input
   initial begin
      wait (!reset);
      repeat (600) @(posedge clock);
      hold_rsp = 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // response side: random ready, compare each beat with the oldest expectation
   initial begin
      norm_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_norms.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response beat");
            end else begin
               want = expected_norms.pop_front();
               if (rsp_bus.norm_re !== want.re || rsp_bus.norm_im !== want.im ||
                   rsp_bus.zero_magnitude !== want.zero) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected re %0d im %0d zero %0b, ",
                               "got re %0d im %0d zero %0b"},
                              want.re, want.im, want.zero, rsp_bus.norm_re,
                              rsp_bus.norm_im, rsp_bus.zero_magnitude);
               end
            end
         end
         rsp_bus.ready <= !hold_rsp && (calm || $urandom_range(99) >= 35);
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      while (expected_norms.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule

### files.f
rtl/core/cpsn_pkg.sv
rtl/core/cpsn_req_if.sv
rtl/core/cross_power_spectrum_normalizer_top.sv
rtl/core/cpsn_checker.sv
tb/sv/tb_cross_power_spectrum_normalizer_top.sv
